[hw/rtl/kpd_pkg.sv]
package kpd_pkg;

    localparam int DIGIT_COUNT_DEF = 4;

    // Item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_TEXT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_DOTS   = 3'd3;
    localparam logic [2:0] KIND_GETKEY = 3'd4;

    // Key answers
    localparam logic [3:0] CODE_STAR  = 4'd10;
    localparam logic [3:0] CODE_HASH  = 4'd11;
    localparam logic [3:0] CODE_CHORD = 4'd12;
    localparam logic [3:0] CODE_NONE  = 4'd13;

    localparam logic [7:0]  DOT_BIT        = 8'h04;
    localparam logic [2:0]  COLS_IDLE      = 3'b111;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

    // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit n
    localparam logic [31:0] DIV10_RECIP = 32'hcccc_cccd;
    localparam int          DIV10_SHIFT = 35;

    // Key status handed from the scanner to the result stage
    typedef struct packed {
        logic       key_available;
        logic [3:0] key_code;
    } kpd_key_stat_t;

    function automatic logic [7:0] digit_form(input logic [3:0] d);
        logic [7:0] seg;
        begin
            case (d)
                4'd0:    seg = 8'hfa;
                4'd1:    seg = 8'h50;
                4'd2:    seg = 8'hb9;
                4'd3:    seg = 8'h79;
                4'd4:    seg = 8'h53;
                4'd5:    seg = 8'h6b;
                4'd6:    seg = 8'heb;
                4'd7:    seg = 8'h58;
                4'd8:    seg = 8'hfb;
                4'd9:    seg = 8'h7b;
                default: seg = 8'h00;
            endcase
            return seg;
        end
    endfunction

    // Character code to segment byte; anything unknown is blank
    function automatic logic [7:0] glyph(input logic [7:0] ch);
        logic [7:0] seg;
        begin
            if (ch >= 8'h30 && ch <= 8'h39)
            begin
                seg = digit_form(4'(ch - 8'h30));
            end
            else
            begin
                case (ch)
                    8'h2d:   seg = 8'h01; // '-'
                    8'h5f:   seg = 8'h20; // '_'
                    8'h45:   seg = 8'hab; // 'E'
                    8'h72:   seg = 8'h81; // 'r'
                    8'h64:   seg = 8'hf1; // 'd'
                    8'h75:   seg = 8'he0; // 'u'
                    8'h70:   seg = 8'h9b; // 'p'
                    8'h62:   seg = 8'he3; // 'b'
                    8'h74:   seg = 8'ha3; // 't'
                    8'h6e:   seg = 8'hc1; // 'n'
                    8'h41:   seg = 8'hdb; // 'A'
                    8'h59:   seg = 8'h73; // 'Y'
                    8'h68:   seg = 8'hc3; // 'h'
                    8'h43:   seg = 8'haa; // 'C'
                    8'h4c:   seg = 8'ha2; // 'L'
                    default: seg = 8'h00;
                endcase
            end
            return seg;
        end
    endfunction

    // Decode a row slot and an active-low column sample into a key code
    function automatic logic [3:0] key_of(input logic [2:0] slot, input logic [2:0] cols);
        logic [3:0] c;
        logic [3:0] r;
        logic [3:0] k;
        logic       ok;
        begin
            ok = 1'b1;
            c  = 4'd0;
            r  = 4'd0;
            case (cols)
                3'b011:  c = 4'd0;
                3'b101:  c = 4'd1;
                3'b110:  c = 4'd2;
                default: ok = 1'b0;
            endcase
            if (slot == 3'd0)
            begin
                r = 4'd3;
            end
            else if (slot <= 3'd3)
            begin
                r = 4'(slot - 3'd1);
            end
            else
            begin
                ok = 1'b0;
            end
            k = 4'(4'd1 + 4'(r * 4'd3) + c);
            if (k == CODE_HASH)
            begin
                k = 4'd0;
            end
            else if (k == CODE_CHORD)
            begin
                k = CODE_HASH;
            end
            return ok ? k : CODE_CHORD;
        end
    endfunction

endpackage

[hw/rtl/keypad_display_scanner.sv]
// Multiplexed seven-segment display (DIGIT_COUNT digits, four by default) with
// a 4x3 keypad scanner. Each input beat is one command: tick (advance the scan,
// sample the keypad columns), write four characters, write a decimal number,
// set the dot segments, or fetch the latched key. Every command beat produces
// exactly one result beat carrying the segment byte and index of the digit
// now driven, the key-available flag and the key answer (13 when none).
// Sequencing: an accepted tick, text, dots or get-key command moves to S_EXEC
// and commits there once the result register is free, then the sequencer goes
// back to S_IDLE, where the next beat is taken. A number write first waits in
// S_CONV on the divide-by-ten unit, which runs a multiply step and a correction
// step for each digit, and then commits from S_EXEC in the same way. One
// command is in flight at a time; the result register lets a new command
// enter while the previous result still waits on result_stall, and that
// command then holds until the waiting result is taken.
// The per-digit lanes rewrite all digits of a text or dots command at once and
// a commit writes them to the display store together with the keypad
// state. debounce_ticks is taken on any cfg_valid beat (cfg_ready stays high)
// and must only be written while no command is in flight.
module keypad_display_scanner
    import kpd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  kind,
    input  logic [2:0]  key_cols,
    input  logic [7:0]  text_char0,
    input  logic [7:0]  text_char1,
    input  logic [7:0]  text_char2,
    input  logic [7:0]  text_char3,
    input  logic [31:0] number_value,
    input  logic [3:0]  dot_mask,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  segments,
    output logic [1:0]  digit_select,
    output logic        key_available,
    output logic [3:0]  key_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] debounce_ticks
);

    localparam int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EXEC} state_t;

    state_t      state_reg;
    logic        result_valid_reg;
    logic [15:0] debounce_ticks_reg;

    // command beat held while it executes
    logic [2:0]  kind_reg;
    logic [2:0]  cols_reg;
    logic [7:0]  text_reg [4];
    logic [3:0]  dots_reg;

    logic [7:0]  segments_reg;
    logic [1:0]  digit_select_reg;
    logic        key_available_reg;
    logic [3:0]  key_code_reg;

    // display store, digit 0 leftmost
    logic [7:0]  store_reg [DIGIT_COUNT];

    logic                        accept;
    logic                        out_free;
    logic                        commit;
    logic                        conv_done;
    logic [DIGIT_COUNT-1:0][7:0] conv_digits;
    logic [SCAN_W-1:0]           scan_next;
    kpd_key_stat_t               key_stat;
    logic [7:0]                  lane_seg [DIGIT_COUNT];
    logic [DIGIT_COUNT:0]        ended;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    // commit the command once the result register can take its beat
    assign commit     = (state_reg == S_EXEC) && out_free;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debounce_ticks_reg <= debounce_ticks;
        end
    end

    // Sequencer and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a commit refills the result register in the cycle it drains
            if (commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (kind == KIND_NUMBER) ? S_CONV : S_EXEC;
                    end
                end
                S_CONV:
                begin
                    if (conv_done)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the command beat and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            cols_reg    <= key_cols;
            text_reg[0] <= text_char0;
            text_reg[1] <= text_char1;
            text_reg[2] <= text_char2;
            text_reg[3] <= text_char3;
            dots_reg    <= dot_mask;
        end
        if (commit)
        begin
            segments_reg      <= lane_seg[scan_next];
            digit_select_reg  <= 2'(scan_next);
            key_available_reg <= key_stat.key_available;
            key_code_reg      <= key_stat.key_code;
        end
    end

    // Display store: reset blanks every digit, commit takes the lane results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                store_reg[i] <= lane_seg[i];
            end
        end
    end

    kpd_dec #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept && (kind == KIND_NUMBER)),
        .value  (number_value),
        .done   (conv_done),
        .digits (conv_digits)
    );

    kpd_scan #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .SCAN_W      (SCAN_W)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (commit),
        .kind           (kind_reg),
        .key_cols       (cols_reg),
        .debounce_ticks (debounce_ticks_reg),
        .scan_next      (scan_next),
        .stat           (key_stat)
    );

    // One lane per digit; the NUL flag ripples left to right across lanes.
    // Digits past the fourth see a NUL and no dot, so a text write blanks them.
    assign ended[0] = 1'b0;

    for (genvar g = 0; g < DIGIT_COUNT; g++)
    begin : g_lane
        logic [7:0] lane_char;
        logic       lane_dot;

        if (g < 4)
        begin : g_fed
            assign lane_char = text_reg[g];
            assign lane_dot  = dots_reg[g];
        end
        else
        begin : g_blank
            assign lane_char = 8'd0;
            assign lane_dot  = 1'b0;
        end

        kpd_lane u_lane (
            .kind      (kind_reg),
            .text_char (lane_char),
            .ended_in  (ended[g]),
            .dot_on    (lane_dot),
            .num_seg   (conv_digits[g]),
            .cur_seg   (store_reg[g]),
            .ended_out (ended[g+1]),
            .new_seg   (lane_seg[g])
        );
    end

    assign result_valid  = result_valid_reg;
    assign segments      = segments_reg;
    assign digit_select  = digit_select_reg;
    assign key_available = key_available_reg;
    assign key_code      = key_code_reg;

    // A result beat only ever follows a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised without a commit");

    // A delivered key answer always clears the key-available flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && key_code_reg != CODE_NONE |-> !key_available_reg)
        else $error("key answered while still flagged available");

    // The number converter finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> state_reg == S_CONV)
        else $error("number conversion finished outside of its wait state");

    // Key answers never exceed the none code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> key_code_reg <= CODE_NONE)
        else $error("key answer out of range");

endmodule

[hw/rtl/kpd_lane.sv]
module kpd_lane
    import kpd_pkg::*;
(
    input  logic [2:0] kind,
    input  logic [7:0] text_char,
    input  logic       ended_in,
    input  logic       dot_on,
    input  logic [7:0] num_seg,
    input  logic [7:0] cur_seg,
    output logic       ended_out,
    output logic [7:0] new_seg
);

    // Blank from the first NUL onward
    assign ended_out = ended_in | (text_char == 8'd0);

    always_comb
    begin
        case (kind)
            KIND_TEXT:   new_seg = ended_out ? 8'd0 : glyph(text_char);
            KIND_NUMBER: new_seg = num_seg;
            KIND_DOTS:   new_seg = (cur_seg & ~DOT_BIT) | (dot_on ? DOT_BIT : 8'd0);
            default:     new_seg = cur_seg;
        endcase
    end

endmodule

[hw/rtl/kpd_dec.sv]
module kpd_dec
    import kpd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 value,
    output logic                        done,
    output logic [DIGIT_COUNT-1:0][7:0] digits
);

    localparam int CNT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int Q_W   = 64 - DIV10_SHIFT;

    typedef enum logic [1:0] {P_IDLE, P_MUL, P_SUB} phase_t;

    phase_t                      phase_reg;
    logic [CNT_W-1:0]            count_reg;
    logic                        done_reg;
    logic [31:0]                 n_reg;
    logic [Q_W-1:0]              quot_reg;
    logic [DIGIT_COUNT-1:0][7:0] digits_reg;

    logic [63:0]      prod_next;
    logic [31:0]      rem_full;
    logic [7:0]       seg_next;
    logic [CNT_W-1:0] slot;
    logic             last;

    assign prod_next = n_reg * DIV10_RECIP;
    assign rem_full  = n_reg - (32'(quot_reg) << 3) - (32'(quot_reg) << 1);
    // Leading zeros blank, but the rightmost digit always shows
    assign seg_next  = (n_reg == 32'd0 && count_reg != '0) ? 8'd0 : digit_form(rem_full[3:0]);
    assign slot      = CNT_W'(DIGIT_COUNT - 1) - count_reg;
    assign last      = (count_reg == CNT_W'(DIGIT_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == P_SUB) && last;
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= P_MUL;
                        count_reg <= '0;
                    end
                end
                P_MUL:
                begin
                    phase_reg <= P_SUB;
                end
                P_SUB:
                begin
                    if (last)
                    begin
                        phase_reg <= P_IDLE;
                    end
                    else
                    begin
                        phase_reg <= P_MUL;
                        count_reg <= CNT_W'(count_reg + 1'b1);
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == P_IDLE && start)
        begin
            n_reg <= value;
        end
        if (phase_reg == P_MUL)
        begin
            quot_reg <= prod_next[63:DIV10_SHIFT];
        end
        if (phase_reg == P_SUB)
        begin
            digits_reg[slot] <= seg_next;
            n_reg            <= 32'(quot_reg);
        end
    end

    assign done   = done_reg;
    assign digits = digits_reg;

endmodule

[hw/rtl/kpd_scan.sv]
module kpd_scan
    import kpd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    parameter int SCAN_W      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  logic [2:0]        kind,
    input  logic [2:0]        key_cols,
    input  logic [15:0]       debounce_ticks,
    output logic [SCAN_W-1:0] scan_next,
    output kpd_key_stat_t     stat
);

    logic [SCAN_W-1:0] scan_reg;
    logic              latched_reg;
    logic [3:0]        code_reg;
    logic              release_reg;
    logic [15:0]       debounce_reg;

    logic              latched_next;
    logic [3:0]        code_next;
    logic              release_next;
    logic [15:0]       debounce_next;
    logic [3:0]        answer;

    always_comb
    begin
        scan_next     = scan_reg;
        latched_next  = latched_reg;
        code_next     = code_reg;
        release_next  = release_reg;
        debounce_next = debounce_reg;
        answer        = CODE_NONE;
        case (kind)
            KIND_TICK:
            begin
                if (release_reg)
                begin
                    // hold the row until the columns read released
                    if (key_cols == COLS_IDLE)
                    begin
                        release_next  = 1'b0;
                        debounce_next = debounce_ticks;
                    end
                end
                else if (debounce_reg != 16'd0)
                begin
                    debounce_next = 16'(debounce_reg - 16'd1);
                end
                else
                begin
                    scan_next = (scan_reg == SCAN_W'(DIGIT_COUNT - 1)) ? '0
                              : SCAN_W'(scan_reg + 1'b1);
                    if (key_cols != COLS_IDLE)
                    begin
                        latched_next = 1'b1;
                        code_next    = key_of(3'(scan_next), key_cols);
                        release_next = 1'b1;
                    end
                end
            end
            KIND_GETKEY:
            begin
                if (latched_reg)
                begin
                    latched_next = 1'b0;
                    answer       = code_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= '0;
            latched_reg  <= 1'b0;
            code_reg     <= 4'd0;
            release_reg  <= 1'b0;
            debounce_reg <= 16'd0;
        end
        else if (commit)
        begin
            scan_reg     <= scan_next;
            latched_reg  <= latched_next;
            code_reg     <= code_next;
            release_reg  <= release_next;
            debounce_reg <= debounce_next;
        end
    end

    assign stat.key_available = latched_next;
    assign stat.key_code      = answer;

endmodule

[verif/tb_top.sv]
module tb_top;
    import kpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kinds the block has to ignore
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    // Active-low column samples with exactly one column pressed
    localparam logic [2:0] COL_LEFT  = 3'b011;
    localparam logic [2:0] COL_MID   = 3'b101;
    localparam logic [2:0] COL_RIGHT = 3'b110;

    // Longest quiet stretch we tolerate; it lies above the receiver hold-off below
    localparam int QUIET_LIMIT = 2000;
    // Pause that covers the slowest command, a number write
    localparam int SETTLE_CYCLES = 16;
    localparam int BEATS_PER_PHASE = 285;

    typedef struct packed {
        logic [7:0] seg;
        logic [1:0] sel;
        logic       avail;
        logic [3:0] code;
    } disp_res_t;

    // One row of stimulus. A row with wr_cfg set is a register write and
    // carries the new debounce_ticks value in num[15:0].
    typedef struct packed {
        logic        wr_cfg;
        logic        pinned;
        disp_res_t   want;
        logic [2:0]  kind;
        logic [2:0]  cols;
        logic [31:0] chars;
        logic [31:0] num;
        logic [3:0]  dots;
    } cmd_t;

    localparam disp_res_t ANY_RES    = '0;
    localparam disp_res_t BLANK_IDLE = '{8'h00, 2'd0, 1'b0, CODE_NONE};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [2:0]  kind = '0;
    logic [2:0]  key_cols = '0;
    logic [7:0]  text_char0 = '0;
    logic [7:0]  text_char1 = '0;
    logic [7:0]  text_char2 = '0;
    logic [7:0]  text_char3 = '0;
    logic [31:0] number_value = '0;
    logic [3:0]  dot_mask = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  segments;
    logic [1:0]  digit_select;
    logic        key_available;
    logic [3:0]  key_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] debounce_ticks = '0;

    // Pinned expectation travels with the beat on the input side
    logic        beat_pinned = 1'b0;
    disp_res_t   beat_want = '0;

    // Predictor state: shadow display store and keypad scanner
    logic [7:0]  disp_store [4];
    logic [1:0]  row_sel;
    logic        key_ready;
    logic [3:0]  key_latch_code;
    logic        wait_release;
    logic [15:0] settle_count;
    logic [15:0] settle_ticks;

    disp_res_t   pending_results [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          send_calm = 1'b0;
    string       glyph_chars = "0123456789-_ErdupbtnAYhCL";

    cmd_t script [25] = '{
        // after reset nothing is latched and the display is blank
        '{1'b0, 1'b1, BLANK_IDLE, KIND_GETKEY, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // unknown character, a letter, then a terminator: digit 0 stays blank
        '{1'b0, 1'b1, BLANK_IDLE, KIND_TEXT, COLS_IDLE, {8'hff, "E", 8'h00, "8"},
          32'd0, 4'h0},
        // zero lands in the rightmost digit only
        '{1'b0, 1'b1, BLANK_IDLE, KIND_NUMBER, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // 4294967295 keeps its low four digits, "7295"
        '{1'b0, 1'b1, '{8'h58, 2'd0, 1'b0, CODE_NONE}, KIND_NUMBER, COLS_IDLE, 32'h0,
          32'hffff_ffff, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_NUMBER, COLS_IDLE, 32'h0, 32'd10000, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_DOTS, COLS_IDLE, 32'h0, 32'd0, 4'hf},
        '{1'b0, 1'b0, ANY_RES, KIND_DOTS, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // every non-digit glyph of the character table
        '{1'b0, 1'b0, ANY_RES, KIND_TEXT, COLS_IDLE, "-_Er", 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TEXT, COLS_IDLE, "dupb", 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TEXT, COLS_IDLE, "tnAY", 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TEXT, COLS_IDLE, "hCL9", 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_UNUSED_LO, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_UNUSED_HI, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // drop the debounce pause so the key sequence below stays short
        '{1'b1, 1'b0, ANY_RES, KIND_TICK, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // two columns at once latch a chord
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, 3'b001, 32'h0, 32'd0, 4'h0},
        // still held: the row must not move
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COL_LEFT, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // a new key overwrites the unretrieved chord
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COL_RIGHT, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_GETKEY, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COL_MID, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_TICK, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        '{1'b0, 1'b0, ANY_RES, KIND_GETKEY, COLS_IDLE, 32'h0, 32'd0, 4'h0},
        // nothing left to fetch
        '{1'b0, 1'b0, ANY_RES, KIND_GETKEY, COLS_IDLE, 32'h0, 32'd0, 4'h0}
    };

    // Debounce settings of the random phases; the longest one goes last since
    // the scan may then sit in its pause for the rest of the run
    logic [15:0] phase_debounce [5] = '{16'd1, 16'd0, 16'd4, 16'd2, 16'hffff};

    keypad_display_scanner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .key_cols       (key_cols),
        .text_char0     (text_char0),
        .text_char1     (text_char1),
        .text_char2     (text_char2),
        .text_char3     (text_char3),
        .number_value   (number_value),
        .dot_mask       (dot_mask),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .segments       (segments),
        .digit_select   (digit_select),
        .key_available  (key_available),
        .key_code       (key_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .debounce_ticks (debounce_ticks)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [7:0] digit_segments(input int d);
        case (d)
            0:       return 8'hfa;
            1:       return 8'h50;
            2:       return 8'hb9;
            3:       return 8'h79;
            4:       return 8'h53;
            5:       return 8'h6b;
            6:       return 8'heb;
            7:       return 8'h58;
            8:       return 8'hfb;
            default: return 8'h7b;
        endcase
    endfunction

    function automatic logic [7:0] char_segments(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
        begin
            return digit_segments(int'(ch) - int'("0"));
        end
        case (ch)
            "-":     return 8'h01;
            "_":     return 8'h20;
            "E":     return 8'hab;
            "r":     return 8'h81;
            "d":     return 8'hf1;
            "u":     return 8'he0;
            "p":     return 8'h9b;
            "b":     return 8'he3;
            "t":     return 8'ha3;
            "n":     return 8'hc1;
            "A":     return 8'hdb;
            "Y":     return 8'h73;
            "h":     return 8'hc3;
            "C":     return 8'haa;
            "L":     return 8'ha2;
            default: return 8'h00;
        endcase
    endfunction

    // Row slot 0 is the bottom keypad row (star, 0, hash); slots 1..3 are the
    // rows 1-2-3, 4-5-6 and 7-8-9
    function automatic logic [3:0] keypad_code(input logic [1:0] slot, input logic [2:0] cols);
        int col;
        case (cols)
            COL_LEFT:  col = 0;
            COL_MID:   col = 1;
            COL_RIGHT: col = 2;
            default:   return CODE_CHORD;
        endcase
        if (slot == 2'd0)
        begin
            return (col == 0) ? CODE_STAR : (col == 1) ? 4'd0 : CODE_HASH;
        end
        return 4'(int'(slot) * 3 + col - 2);
    endfunction

    // Apply one command beat to the shadow state and return the result beat
    task automatic apply_command(input logic [2:0] k, input logic [2:0] cols,
                                 input logic [31:0] chars, input logic [31:0] num,
                                 input logic [3:0] dots, output disp_res_t res);
        logic [7:0]  ch;
        logic [31:0] n;
        bit          ended;
        logic [3:0]  answer;
        answer = CODE_NONE;
        case (k)
            KIND_TICK:
            begin
                if (wait_release)
                begin
                    // hold the row until all columns read released
                    if (cols == COLS_IDLE)
                    begin
                        wait_release = 1'b0;
                        settle_count = settle_ticks;
                    end
                end
                else if (settle_count != 0)
                begin
                    settle_count = settle_count - 16'd1;
                end
                else
                begin
                    row_sel = row_sel + 2'd1;
                    if (cols != COLS_IDLE)
                    begin
                        key_ready = 1'b1;
                        key_latch_code = keypad_code(row_sel, cols);
                        wait_release = 1'b1;
                    end
                end
            end
            KIND_TEXT:
            begin
                ended = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    ch = chars[31 - 8 * i -: 8];
                    if (ch == 8'h00)
                    begin
                        ended = 1'b1;
                    end
                    disp_store[i] = ended ? 8'h00 : char_segments(ch);
                end
            end
            KIND_NUMBER:
            begin
                // right-aligned, leading zeros blank
                n = num;
                for (int i = 3; i >= 0; i--)
                begin
                    disp_store[i] = (n == 0 && i != 3) ? 8'h00 : digit_segments(int'(n % 10));
                    n = n / 10;
                end
            end
            KIND_DOTS:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    disp_store[i] = (disp_store[i] & ~DOT_BIT) | (dots[i] ? DOT_BIT : 8'h00);
                end
            end
            KIND_GETKEY:
            begin
                if (key_ready)
                begin
                    key_ready = 1'b0;
                    answer = key_latch_code;
                end
            end
            default:
            begin
            end
        endcase
        res.seg   = disp_store[row_sel];
        res.sel   = row_sel;
        res.avail = key_ready;
        res.code  = answer;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Shadow reset state
    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            disp_store[i] = 8'h00;
        end
        row_sel        = 2'd0;
        key_ready      = 1'b0;
        key_latch_code = 4'd0;
        wait_release   = 1'b0;
        settle_count   = 16'd0;
        settle_ticks   = DEBOUNCE_RESET;
    end

    // Monitor: retire result beats first, then predict the command beat taken
    // at the same edge (with one command in flight they never belong together)
    always @(posedge clk)
    begin
        disp_res_t got;
        disp_res_t want;
        disp_res_t predicted;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                settle_ticks = debounce_ticks;
            end
            if (result_valid && !result_stall)
            begin
                got = '{segments, digit_select, key_available, key_code};
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("segments", want.seg, got.seg);
                    check_field("digit_select", want.sel, got.sel);
                    check_field("key_available", want.avail, got.avail);
                    check_field("key_code", want.code, got.code);
                end
            end
            if (item_valid && !item_stall)
            begin
                apply_command(kind, key_cols,
                              {text_char0, text_char1, text_char2, text_char3},
                              number_value, dot_mask, predicted);
                pending_results.push_back(beat_pinned ? beat_want : predicted);
            end
        end
    end

    // Watchdog: end the run if no channel moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: random stall before each beat, calm stretches without stalls,
    // and now and then a long hold-off so the block backs up into its input
    initial
    begin : receiver
        int  hold;
        int  beats_taken;
        bit  calm;
        beats_taken = 0;
        calm = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                calm = !calm;
            end
            hold = calm ? 0 : $urandom_range(0, 19);
            if (beats_taken % 600 == 300)
            begin
                hold = 120;
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            beats_taken++;
        end
    end

    // Offer one command beat, after a random gap, and hold it until taken
    task automatic offer(input cmd_t c);
        int gap;
        if ($urandom_range(0, 39) == 0)
        begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind         <= c.kind;
        key_cols     <= c.cols;
        {text_char0, text_char1, text_char2, text_char3} <= c.chars;
        number_value <= c.num;
        dot_mask     <= c.dots;
        beat_pinned  <= c.pinned;
        beat_want    <= c.want;
        item_valid   <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Drain every outstanding result and let the block settle
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] value);
        drain();
        cfg_valid      <= 1'b1;
        debounce_ticks <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 8'h00;
        end
        if (r < 22)
        begin
            return 8'($urandom_range(0, 255));
        end
        return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
    endfunction

    // Random command: mostly key traffic (presses, holds, releases, fetches),
    // display writes in between; unused fields always carry noise
    function automatic cmd_t random_command();
        cmd_t c;
        int   r;
        c.wr_cfg = 1'b0;
        c.pinned = 1'b0;
        c.want   = ANY_RES;
        c.cols   = 3'($urandom_range(0, 7));
        c.chars  = $urandom;
        c.num    = $urandom;
        c.dots   = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            c.kind = KIND_TICK;
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                c.cols = COLS_IDLE;
            end
            else if (r < 88)
            begin
                c.cols = (r < 66) ? COL_LEFT : (r < 77) ? COL_MID : COL_RIGHT;
            end
        end
        else if (r < 55)
        begin
            c.kind  = KIND_TEXT;
            c.chars = {pick_char(), pick_char(), pick_char(), pick_char()};
        end
        else if (r < 65)
        begin
            c.kind = KIND_NUMBER;
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                c.num = $urandom_range(0, 99);
            end
            else if (r < 70)
            begin
                c.num = $urandom_range(0, 20000);
            end
        end
        else if (r < 73)
        begin
            c.kind = KIND_DOTS;
        end
        else if (r < 93)
        begin
            c.kind = KIND_GETKEY;
        end
        else
        begin
            c.kind = 3'($urandom_range(int'(KIND_UNUSED_LO), int'(KIND_UNUSED_HI)));
        end
        return c;
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the first part runs with the debounce reset value
        foreach (script[i])
        begin
            if (script[i].wr_cfg)
            begin
                write_debounce(script[i].num[15:0]);
            end
            else
            begin
                offer(script[i]);
            end
        end

        foreach (phase_debounce[p])
        begin
            write_debounce(phase_debounce[p]);
            repeat (BEATS_PER_PHASE)
            begin
                offer(random_command());
            end
        end

        drain();
        if (errors == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/kpd_pkg.sv
hw/rtl/kpd_lane.sv
hw/rtl/kpd_dec.sv
hw/rtl/kpd_scan.sv
hw/rtl/keypad_display_scanner.sv
verif/tb_top.sv
